// ===== rtl/gaag_pkg.sv =====
// gaag_pkg: shared types and constants for the gather-along-axis address generator.
// Used by every module under rtl/; depends on nothing.
package gaag_pkg;

  // Fixed field widths of the streaming and configuration ports
  localparam int DATA_W      = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int GATHER_AX_W = 3;

  // Front-to-back request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_SHAPE = 2'd0,
    CFG_INDEX_SHAPE = 2'd1,
    CFG_GATHER_AXIS = 2'd2
  } cfg_reg_t;

  // Stride derivation sequencer
  typedef enum logic {
    SG_IDLE = 1'b0,
    SG_RUN  = 1'b1
  } stride_state_t;

  // Queue occupancy status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/gather_along_axis_address_gen.sv =====
// gather_along_axis_address_gen: top level of the gather address generator.
// Depends on gaag_pkg, gaag_stride_gen, gaag_front, gaag_queue and gaag_back.
//
//   channel  direction  handshake            payload
//   in_      slave      tvalid/tready        tdata[63:0]  index_value (signed)
//   out_     master     tvalid/tready        tdata[63:0]  source_offset,
//                                             tdata[127:64] dest_offset, tlast last_element
//   cfg_     write      we (no wait)          index[1:0], wdata[63:0]
//
// One request per cycle sustained while the output is taken and no stride pass runs;
// a result is offered after its input accept passes the queue slot, product stage,
// pairwise-sum stage, then the output register. Reset is synchronous, active low;
// after reset and after every input_shape write the stride sequencer walks one axis
// per cycle, with in_tready low. A stalled output holds the whole back pipeline; the
// two-entry queue then fills and in_tready falls.
module gather_along_axis_address_gen import gaag_pkg::*; #(
  parameter int RANK           = 4,
  parameter int AXIS_SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // index stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [63:0] index_value
  // address stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*DATA_W-1:0]   out_tdata,  // [63:0] source_offset, [127:64] dest_offset
  output logic                  out_tlast
);

  localparam int ASB = AXIS_SIZE_BITS;
  localparam int EW  = RANK * ASB + DATA_W + 1;

  logic                        shape_load;
  logic                        stride_busy;
  logic [RANK-1:0][ASB-1:0]    in_size;
  logic [RANK-1:0][DATA_W-1:0] stride;
  logic                        push, pop;
  logic [RANK-1:0][ASB-1:0]    push_coord, head_coord;
  logic [DATA_W-1:0]           push_dest, head_dest;
  logic                        push_last, head_last;
  logic [EW-1:0]               q_din, q_dout;
  q_status_t                   q_status;
  logic                        space_ok;

  assign space_ok = !q_status.full && !stride_busy;

  gaag_front #(.RANK(RANK), .ASB(ASB)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .space_ok   (space_ok),
    .push       (push),
    .push_coord (push_coord),
    .push_dest  (push_dest),
    .push_last  (push_last),
    .in_size    (in_size),
    .shape_load (shape_load)
  );

  gaag_stride_gen #(.RANK(RANK), .ASB(ASB)) u_stride (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (shape_load),
    .in_size (in_size),
    .stride  (stride),
    .busy    (stride_busy)
  );

  // request packing: coordinates, destination, last flag
  assign q_din = {push_last, push_dest, push_coord};
  assign {head_last, head_dest, head_coord} = q_dout;

  gaag_queue #(.EW(EW)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (q_din),
    .pop    (pop),
    .dout   (q_dout),
    .status (q_status)
  );

  gaag_back #(.RANK(RANK), .ASB(ASB)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head_coord (head_coord),
    .head_dest  (head_dest),
    .head_last  (head_last),
    .pop        (pop),
    .stride     (stride),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/gaag_stride_gen.sv =====
// gaag_stride_gen: derives the row-major input strides from the input axis sizes,
// one axis per cycle, innermost first. Depends on gaag_pkg.
module gaag_stride_gen import gaag_pkg::*; #(
  parameter int RANK = 4,
  parameter int ASB  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [RANK-1:0][ASB-1:0]    in_size,
  output logic [RANK-1:0][DATA_W-1:0] stride,
  output logic                        busy
);

  localparam int IDX_W = (RANK > 1) ? $clog2(RANK) : 1;
  localparam logic [IDX_W-1:0] LAST_AX = IDX_W'(RANK - 1);

  stride_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [DATA_W-1:0]         acc_r, acc_nxt;
  logic [RANK-1:0][DATA_W-1:0] stride_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SG_IDLE: begin
        if (load) state_nxt = SG_RUN;
      end
      SG_RUN: begin
        if (!load && idx_r == '0) state_nxt = SG_IDLE;
      end
      default: state_nxt = SG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r == SG_RUN);
  end

  // running product walks outward
  always_comb begin
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    if (load) begin
      idx_nxt = LAST_AX;
      acc_nxt = DATA_W'(1);
    end else if (state_r == SG_RUN) begin
      idx_nxt = idx_r - 1'b1;
      acc_nxt = acc_r * DATA_W'(in_size[idx_r]);
    end
  end

  // reset kicks off a derivation from the reset shape
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SG_RUN;
      idx_r   <= LAST_AX;
      acc_r   <= DATA_W'(1);
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SG_RUN && !load) begin
      stride_r[idx_r] <= acc_r;
    end
  end

  assign stride = stride_r;

  // outermost axis ends the pass
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SG_RUN && idx_r == '0 && !load) |=> (state_r == SG_IDLE))
    else $error("stride pass did not end after the outermost axis");

endmodule

// ===== rtl/gaag_front.sv =====
// gaag_front: configuration registers, index normalization and output coordinate
// tracking; produces one address request per accepted index. Depends on gaag_pkg.
module gaag_front import gaag_pkg::*; #(
  parameter int RANK = 4,
  parameter int ASB  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [DATA_W-1:0]        in_tdata,
  input  logic                     space_ok,
  output logic                     push,
  output logic [RANK-1:0][ASB-1:0] push_coord,
  output logic [DATA_W-1:0]        push_dest,
  output logic                     push_last,
  output logic [RANK-1:0][ASB-1:0] in_size,
  output logic                     shape_load
);

  localparam int AX_W = (RANK > 1) ? $clog2(RANK) : 1;

  logic [CFG_W-1:0]               input_shape_r;
  logic [CFG_W-1:0]               index_shape_r;
  logic signed [GATHER_AX_W-1:0]  gather_axis_r;
  logic [RANK-1:0][ASB-1:0]       coord_r, coord_nxt;
  logic [DATA_W-1:0]              count_r, count_nxt;
  logic [RANK-1:0][ASB-1:0]       idx_size;
  logic                           cfg_hit;
  logic                           accept;
  logic [AX_W-1:0]                axis;
  logic [ASB-1:0]                 gsize;
  logic [ASB-1:0]                 norm_idx;
  logic                           last;

  // unpack axis sizes; fields above the register and zero fields read as one
  for (genvar g = 0; g < RANK; g++) begin : g_size
    if (ASB * g < CFG_W) begin : g_in_reg
      logic [CFG_W-1:0] in_sh, ix_sh;
      assign in_sh = input_shape_r >> (ASB * g);
      assign ix_sh = index_shape_r >> (ASB * g);
      assign in_size[g]  = (in_sh[ASB-1:0] == '0) ? ASB'(1) : in_sh[ASB-1:0];
      assign idx_size[g] = (ix_sh[ASB-1:0] == '0) ? ASB'(1) : ix_sh[ASB-1:0];
    end else begin : g_above
      assign in_size[g]  = ASB'(1);
      assign idx_size[g] = ASB'(1);
    end
  end

  // configuration decode
  always_comb begin
    cfg_hit    = 1'b0;
    shape_load = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INPUT_SHAPE: begin
          cfg_hit    = 1'b1;
          shape_load = 1'b1;
        end
        CFG_INDEX_SHAPE: cfg_hit = 1'b1;
        CFG_GATHER_AXIS: cfg_hit = 1'b1;
        default:         cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_shape_r <= CFG_W'(64'h0001_0001_0001_0001);
      index_shape_r <= CFG_W'(64'h0001_0001_0001_0001);
      gather_axis_r <= '0;
    end else if (cfg_we) begin
      if (cfg_reg_t'(cfg_index) == CFG_INPUT_SHAPE) input_shape_r <= cfg_wdata;
      if (cfg_reg_t'(cfg_index) == CFG_INDEX_SHAPE) index_shape_r <= cfg_wdata;
      if (cfg_reg_t'(cfg_index) == CFG_GATHER_AXIS) gather_axis_r <= cfg_wdata[GATHER_AX_W-1:0];
    end
  end

  // resolve the gather axis: negative counts from the last axis, then clamp
  always_comb begin
    int a;
    a = int'(gather_axis_r);
    if (a < 0) a = a + RANK;
    if (a < 0) a = 0;
    if (a > RANK - 1) a = RANK - 1;
    axis = AX_W'(a);
  end

  assign gsize = in_size[axis];

  // wrap negative indexes once, clamp into 0..size-1
  always_comb begin
    logic [DATA_W-1:0] sz, mag, diff;
    sz   = DATA_W'(gsize);
    mag  = DATA_W'(0) - in_tdata;
    diff = sz - mag;
    if (in_tdata[DATA_W-1]) begin
      norm_idx = (mag >= sz) ? '0 : diff[ASB-1:0];
    end else begin
      norm_idx = (in_tdata >= sz) ? (gsize - 1'b1) : in_tdata[ASB-1:0];
    end
  end

  // source coordinate and end-of-stream detect
  always_comb begin
    last = 1'b1;
    for (int i = 0; i < RANK; i++) begin
      push_coord[i] = (AX_W'(i) == axis) ? norm_idx : coord_r[i];
      if ({1'b0, coord_r[i]} + 1'b1 < {1'b0, idx_size[i]}) last = 1'b0;
    end
  end

  // odometer step, innermost axis first
  always_comb begin
    logic             carry;
    logic [ASB:0]     nc;
    coord_nxt = coord_r;
    count_nxt = count_r;
    carry     = 1'b1;
    nc        = '0;
    if (cfg_hit || (accept && last)) begin
      coord_nxt = '0;
      count_nxt = '0;
    end else if (accept) begin
      count_nxt = count_r + 1'b1;
      for (int i = RANK - 1; i >= 0; i--) begin
        nc = {1'b0, coord_r[i]} + 1'b1;
        if (carry) begin
          if (nc >= {1'b0, idx_size[i]}) begin
            coord_nxt[i] = '0;
          end else begin
            coord_nxt[i] = nc[ASB-1:0];
            carry        = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
      count_r <= '0;
    end else begin
      coord_r <= coord_nxt;
      count_r <= count_nxt;
    end
  end

  // handshake
  assign in_tready = space_ok;
  assign accept    = in_tvalid && space_ok;
  assign push      = accept;
  assign push_dest = count_r;
  assign push_last = last;

endmodule

// ===== rtl/gaag_queue.sv =====
// gaag_queue: two-entry request queue between the front and the back.
// Depends on gaag_pkg.
module gaag_queue import gaag_pkg::*; #(
  parameter int EW = 130
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] din,
  input  logic          pop,
  output logic [EW-1:0] dout,
  output q_status_t     status
);

  logic [EW-1:0]     mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  assign dout         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(QUEUE_DEPTH)))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("request popped from an empty queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill level lost a request");

endmodule

// ===== rtl/gaag_back.sv =====
// gaag_back: source offset datapath, per-axis products, pairwise sums, final sum
// into the output register. Depends on gaag_pkg.
module gaag_back import gaag_pkg::*; #(
  parameter int RANK = 4,
  parameter int ASB  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  q_status_t                   q_status,
  input  logic [RANK-1:0][ASB-1:0]    head_coord,
  input  logic [DATA_W-1:0]           head_dest,
  input  logic                        head_last,
  output logic                        pop,
  input  logic [RANK-1:0][DATA_W-1:0] stride,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [2*DATA_W-1:0]         out_tdata,
  output logic                        out_tlast
);

  localparam int NP = (RANK + 1) / 2;

  logic                        en;
  logic                        p_valid_r, h_valid_r, out_valid_r;
  logic [RANK-1:0][DATA_W-1:0] prod_r;
  logic [NP-1:0][DATA_W-1:0]   half_nxt, half_r;
  logic [DATA_W-1:0]           p_dest_r, h_dest_r, out_dest_r;
  logic                        p_last_r, h_last_r, out_last_r;
  logic [DATA_W-1:0]           sum_nxt, out_src_r;

  // whole pipe moves unless the output register is held
  assign en  = !out_valid_r || out_tready;
  assign pop = en && !q_status.empty;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      h_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r   <= pop;
      h_valid_r   <= p_valid_r;
      out_valid_r <= h_valid_r;
    end
  end

  // stage 1: coordinate times stride, modulo 2^64
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RANK; i++) begin
        prod_r[i] <= stride[i] * DATA_W'(head_coord[i]);
      end
      p_dest_r <= head_dest;
      p_last_r <= head_last;
    end
  end

  // stage 2: pairwise sums
  for (genvar k = 0; k < NP; k++) begin : g_pair
    if (2 * k + 1 < RANK) begin : g_two
      assign half_nxt[k] = prod_r[2*k] + prod_r[2*k+1];
    end else begin : g_one
      assign half_nxt[k] = prod_r[2*k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_r   <= half_nxt;
      h_dest_r <= p_dest_r;
      h_last_r <= p_last_r;
    end
  end

  // stage 3: final sum into the output register
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NP; k++) begin
      sum_nxt = sum_nxt + half_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_src_r  <= sum_nxt;
      out_dest_r <= h_dest_r;
      out_last_r <= h_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dest_r, out_src_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for gather_along_axis_address_gen.
// Depends on gaag_pkg and the RTL top; predicts each source/dest offset pair in-line,
// checks results in order and drives random gaps, stalls and register settings.
module tb_top;
  import gaag_pkg::*;

  localparam int RANK         = 4;
  localparam int AXIS_BITS    = 16;
  localparam int MAX_GAP      = 13;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PHASE_CAP    = 120;

  // register index past the end of the list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam logic [63:0] IDX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] IDX_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] src_off;
    logic [63:0] dst_off;
    logic        is_last;
  } addr_pair_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata  = '0;   // [63:0] index_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*DATA_W-1:0]   out_tdata;        // [63:0] source_offset, [127:64] dest_offset
  logic                  out_tlast;

  gather_along_axis_address_gen #(
    .RANK           (RANK),
    .AXIS_SIZE_BITS (AXIS_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // request queues and handshake bookkeeping
  logic [63:0] idx_batch_q[$];
  logic [63:0] idx_pending_q[$];
  addr_pair_t  addr_expect_q[$];
  bit          in_took     = 1'b0;
  bit          out_took    = 1'b0;
  bit          in_steady   = 1'b0;
  bit          out_steady  = 1'b0;
  int          in_gap      = 0;
  int          out_wait    = 0;
  int          hold_req    = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          stall_cycles = 0;
  int          err_count   = 0;

  // shadow of the block: registers, strides, coordinate and element count
  logic [63:0] m_in_shape;
  logic [63:0] m_idx_shape;
  logic [2:0]  m_axis_sel;
  logic [15:0] m_coord [RANK];
  logic [63:0] m_count;
  logic [63:0] m_stride [RANK];

  // axis size from a packed shape; zero means one
  function automatic logic [63:0] axis_len(logic [63:0] shape, int i);
    logic [15:0] v;
    v = shape[AXIS_BITS*i +: AXIS_BITS];
    return (v == '0) ? 64'd1 : {48'd0, v};
  endfunction

  function automatic void rebuild_strides();
    logic [63:0] s;
    s = 64'd1;
    for (int i = RANK - 1; i >= 0; i--) begin
      m_stride[i] = s;
      s = s * axis_len(m_in_shape, i);
    end
  endfunction

  function automatic void rewind_stream();
    for (int i = 0; i < RANK; i++) m_coord[i] = '0;
    m_count = '0;
  endfunction

  // signed axis select, negative counts from the innermost axis
  function automatic int gather_dim();
    int a;
    a = int'($signed(m_axis_sel));
    if (a < 0) a += RANK;
    if (a < 0) a = 0;
    if (a >= RANK) a = RANK - 1;
    return a;
  endfunction

  // wrap negative indexes once, then clamp into 0..len-1
  function automatic logic [63:0] clamp_index(logic [63:0] raw, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] r;
    if (raw[63]) begin
      mag = -raw;
      r = (mag >= len) ? 64'd0 : len - mag;
    end else begin
      r = (raw >= len) ? len - 64'd1 : raw;
    end
    return r;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_INPUT_SHAPE: begin
        m_in_shape = val;
        rebuild_strides();
        rewind_stream();
      end
      CFG_INDEX_SHAPE: begin
        m_idx_shape = val;
        rewind_stream();
      end
      CFG_GATHER_AXIS: begin
        m_axis_sel = val[2:0];
        rewind_stream();
      end
      default: ;
    endcase
  endfunction

  // offsets for one index request, then advance the output coordinate
  function automatic addr_pair_t predict_addresses(logic [63:0] raw);
    addr_pair_t  r;
    int          ax;
    logic [63:0] j;
    logic [63:0] c;
    logic        fin;
    ax = gather_dim();
    j = clamp_index(raw, axis_len(m_in_shape, ax));
    r.src_off = '0;
    fin = 1'b1;
    for (int i = 0; i < RANK; i++) begin
      c = (i == ax) ? j : {48'd0, m_coord[i]};
      r.src_off = r.src_off + c * m_stride[i];
      if ({48'd0, m_coord[i]} + 64'd1 < axis_len(m_idx_shape, i)) fin = 1'b0;
    end
    r.dst_off = m_count;
    r.is_last = fin;
    if (fin) begin
      rewind_stream();
    end else begin
      m_count = m_count + 64'd1;
      for (int i = RANK - 1; i >= 0; i--) begin
        if ({48'd0, m_coord[i]} + 64'd1 >= axis_len(m_idx_shape, i)) begin
          m_coord[i] = '0;
        end else begin
          m_coord[i] = m_coord[i] + 16'd1;
          break;
        end
      end
    end
    return r;
  endfunction

  // random register values: mostly small axes, sometimes the extremes
  function automatic logic [63:0] pick_in_shape();
    logic [63:0] s;
    int unsigned r;
    s = '0;
    case ($urandom_range(0, 11))
      0: s = '0;
      1: s = '1;
      2: s = {$urandom, $urandom};
      default: begin
        for (int i = 0; i < RANK; i++) begin
          r = $urandom_range(0, 11);
          if (r == 10) s[AXIS_BITS*i +: AXIS_BITS] = 16'hFFFF;
          else if (r == 11) s[AXIS_BITS*i +: AXIS_BITS] = 16'($urandom);
          else s[AXIS_BITS*i +: AXIS_BITS] = 16'(r);
        end
      end
    endcase
    return s;
  endfunction

  // index shapes stay small so that frames end often
  function automatic logic [63:0] pick_idx_shape();
    logic [63:0] s;
    s = '0;
    case ($urandom_range(0, 11))
      0: s = '0;
      1: s = '1;
      2: s = {$urandom, $urandom};
      default: begin
        for (int i = 0; i < RANK; i++) begin
          if ($urandom_range(0, 7) == 0) s[AXIS_BITS*i +: AXIS_BITS] = 16'($urandom_range(5, 9));
          else s[AXIS_BITS*i +: AXIS_BITS] = 16'($urandom_range(0, 4));
        end
      end
    endcase
    return s;
  endfunction

  // index values mostly around the valid range of the gathered axis
  function automatic logic [63:0] pick_index(logic [63:0] len);
    logic [63:0] r;
    case ($urandom_range(0, 31))
      0: r = {$urandom, $urandom};
      1: r = IDX_MIN;
      2: r = IDX_MAX;
      3: r = -len;
      4: r = -(len + 64'd1);
      5: r = len;
      default: r = 64'($urandom_range(0, 32'(2 * len + 64'd1))) - (len + 64'd1);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  // register write; called at a falling edge, returns at the next one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_cfg(idx, val);
    @(negedge clk);
  endtask

  // hand the staged batch to the driver and wait until the block is idle again;
  // idle is judged at rising edges, where the driver's last change is settled
  task automatic launch(input bit steady_in, input bit steady_out, input bit squeeze);
    @(posedge clk);
    in_steady  = steady_in;
    out_steady = steady_out;
    if (squeeze) hold_req++;
    while (idx_batch_q.size() != 0) idx_pending_q.push_back(idx_batch_q.pop_front());
    @(posedge clk);
    while (idx_pending_q.size() != 0 || in_tvalid || addr_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // monitor: record accepted requests and check results in order
  always @(posedge clk) begin
    addr_pair_t want;
    out_took = out_tvalid && out_tready;
    in_took  = in_tvalid && in_tready;
    if (out_took) begin
      if (addr_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: src %h dst %h last %b",
                                  out_tdata[63:0], out_tdata[127:64], out_tlast));
      end else begin
        want = addr_expect_q.pop_front();
        if (out_tdata[63:0] !== want.src_off)
          report_mismatch($sformatf("source_offset %h, expected %h (dest %0d)",
                                    out_tdata[63:0], want.src_off, want.dst_off));
        if (out_tdata[127:64] !== want.dst_off)
          report_mismatch($sformatf("dest_offset %h, expected %h",
                                    out_tdata[127:64], want.dst_off));
        if (out_tlast !== want.is_last)
          report_mismatch($sformatf("last_element %b, expected %b (dest %0d)",
                                    out_tlast, want.is_last, want.dst_off));
      end
    end
    if (in_took) addr_expect_q.push_back(predict_addresses(in_tdata));
  end

  // driver: offer pending index requests with random gaps
  always @(negedge clk) begin
    logic        nv;
    logic [63:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (in_took) nv = 1'b0;
    if (!nv && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (idx_pending_q.size() != 0) begin
        nd = idx_pending_q.pop_front();
        nv = 1'b1;
        in_gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // receiver: per-result stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (out_took) out_wait = out_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          phase;
    int          n;
    logic [63:0] frame;
    logic [63:0] len;

    // reset state of the shadow
    m_in_shape  = 64'h0001_0001_0001_0001;
    m_idx_shape = 64'h0001_0001_0001_0001;
    m_axis_sel  = '0;
    rebuild_strides();
    rewind_stream();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every element is the last one, gathered axis has size one
    idx_batch_q = '{64'd0, '1, IDX_MAX, IDX_MIN};
    launch(1'b0, 1'b0, 1'b0);

    // widest gathered axis, zero-sized axes, off-axis index size above input size,
    // gather axis given as -4
    write_reg(CFG_INPUT_SHAPE, 64'h0005_0003_0000_FFFF);
    write_reg(CFG_INDEX_SHAPE, 64'h0007_0003_0000_0002);
    write_reg(CFG_GATHER_AXIS, 64'h0000_0000_0000_0004);
    cfg_we <= 1'b0;
    idx_batch_q = '{64'd0, 64'd1, 64'hFFFE, 64'hFFFF, 64'h1_0000, '1, -64'd65535,
                    -64'd65536, -64'd65537, IDX_MIN, IDX_MAX, 64'd7};
    launch(1'b1, 1'b0, 1'b0);

    // a write past the register list must not restart the stream
    write_reg(CFG_NO_REG, '1);
    cfg_we <= 1'b0;
    idx_batch_q = '{64'd3, -64'd2, 64'd40000};
    launch(1'b0, 1'b1, 1'b0);

    // all-ones input shape, innermost axis, upper write bits ignored
    write_reg(CFG_INPUT_SHAPE, '1);
    write_reg(CFG_GATHER_AXIS, 64'hA5A5_0000_0000_0003);
    write_reg(CFG_INDEX_SHAPE, 64'h0002_0001_0001_0002);
    cfg_we <= 1'b0;
    idx_batch_q = '{IDX_MAX, IDX_MIN, 64'hFFFE, '1, 64'd5, 64'd0};
    launch(1'b0, 1'b0, 1'b0);

    // random phases: new settings, then whole frames with random indexes
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(CFG_INPUT_SHAPE, pick_in_shape());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(CFG_INDEX_SHAPE, pick_idx_shape());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(CFG_GATHER_AXIS, {$urandom, $urandom});
      if ($urandom_range(0, 7) == 0) write_reg(CFG_NO_REG, {$urandom, $urandom});
      cfg_we <= 1'b0;

      frame = 64'd1;
      for (int i = 0; i < RANK; i++) begin
        frame = frame * axis_len(m_idx_shape, i);
        if (frame > 64'd4096) frame = 64'd4096;
      end
      n = int'(frame) * $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0) n += $urandom_range(1, int'(frame));
      if (n > PHASE_CAP) n = PHASE_CAP;
      // the pressure phase needs enough requests to back up the input
      if (phase == 2) n = PHASE_CAP;

      len = axis_len(m_in_shape, gather_dim());
      for (int k = 0; k < n; k++) idx_batch_q.push_back(pick_index(len));

      if (phase == 2) launch(1'b1, 1'b0, 1'b1);
      else launch($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'b0);
      sent += n;
      phase++;
    end

    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gaag_pkg.sv
rtl/gaag_stride_gen.sv
rtl/gaag_front.sv
rtl/gaag_queue.sv
rtl/gaag_back.sv
rtl/gather_along_axis_address_gen.sv
tb/sv/tb_top.sv
